FILE: src/lob_pkg.sv
package lob_pkg;

	localparam int SYM_W = 16;
	localparam int KIND_W = 2;
	localparam int PRICE_W = 32;
	localparam int QTY_W = 32;
	localparam int TIME_W = 48;
	localparam int FILLS_W = 32;
	localparam int VOL_W = 64;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = KIND_W;
	localparam int M_TDATA_W = 168;

	localparam int RESULT_LIMIT = 64;
	localparam int K_W = 7;

	localparam logic [KIND_W-1:0] KIND_LIMIT = 2'd0;
	localparam logic SIDE_BUY = 1'b0;

	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_SYMBOL   = 2'd1,
		ST_KIND     = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BOOK_HOLD,
		BOOK_INSERT,
		BOOK_POP,
		BOOK_SETQ
	} book_op_t;

	typedef enum logic [1:0] {
		OUT_HOLD,
		OUT_PLAIN,
		OUT_PEND
	} out_sel_t;

	typedef struct packed {
		logic     take;
		logic     insert;
		logic     match;
		out_sel_t out_sel;
		status_t  out_status;
	} ctl_cmd_t;

	typedef struct packed {
		status_t check;
		logic    crossed;
	} dp_stat_t;

endpackage

FILE: src/limit_order_book_matcher_unit.sv
// Limit order book for one instrument with price-time priority. Orders arrive
// one per transaction on the slave stream; each produces either one status
// result or one result per fill, with tlast on the final one. The block works
// on one order at a time: a rejected order goes from CHECK straight to SEND, an
// accepted order is inserted in CHECK and then judged in EVAL, and the master
// side can stall any result. The books are rows of registers that insert or
// shift out one entry per cycle, and each fill must update both book heads
// before the next price cross can be judged; every fill is then judged in EVAL
// and presented on the master side in SEND.
module limit_order_book_matcher_unit #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lob_pkg::SYM_W-1:0]     cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// order_symbol, order_side, order_price, order_quantity, order_time
	input  logic [lob_pkg::S_TDATA_W-1:0] s_tdata,
	// order_kind
	input  logic [lob_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status, fill_quantity, fill_price, filled_total, volume_total
	output logic [lob_pkg::M_TDATA_W-1:0] m_tdata,
	// fill_valid
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import lob_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	lob_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
		.stat(stat), .cmd(cmd)
	);

	lob_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.cmd(cmd), .stat(stat),
		.m_tdata(m_tdata), .m_tuser(m_tuser)
	);

endmodule

FILE: src/lob_book.sv
module lob_book #(
	parameter int DEPTH = 32,
	parameter bit IS_BID = 1'b1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lob_pkg::book_op_t             op,
	input  logic [lob_pkg::PRICE_W-1:0]   new_price,
	input  logic [lob_pkg::QTY_W-1:0]     new_qty,
	input  logic [lob_pkg::TIME_W-1:0]    new_time,
	input  logic [lob_pkg::QTY_W-1:0]     set_qty,
	output logic [lob_pkg::PRICE_W-1:0]   head_price,
	output logic [lob_pkg::QTY_W-1:0]     head_qty,
	output logic                          nonempty,
	output logic                          full
);
	import lob_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      count_q;
	logic [PRICE_W-1:0] price_q [DEPTH];
	logic [QTY_W-1:0]   qty_q [DEPTH];
	logic [TIME_W-1:0]  time_q [DEPTH];
	logic [DEPTH-1:0]   slot;

	// A slot is set where the new order ranks ahead of the entry or the entry
	// is unused; the set slots form one run that reaches the end of the row.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
		logic better;
		always_comb begin
			if (IS_BID) begin
				better = new_price > price_q[i];
			end else begin
				better = new_price < price_q[i];
			end
			better = better || (new_price == price_q[i] && new_time < time_q[i]);
			slot[i] = (CW'(i) >= count_q) || better;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			case (op)
				BOOK_INSERT: begin
					if (slot[i]) begin
						if (i == 0) begin
							price_q[i] <= new_price;
							qty_q[i] <= new_qty;
							time_q[i] <= new_time;
						end else if (!slot[(i == 0) ? 0 : i - 1]) begin
							price_q[i] <= new_price;
							qty_q[i] <= new_qty;
							time_q[i] <= new_time;
						end else begin
							price_q[i] <= price_q[(i == 0) ? 0 : i - 1];
							qty_q[i] <= qty_q[(i == 0) ? 0 : i - 1];
							time_q[i] <= time_q[(i == 0) ? 0 : i - 1];
						end
					end
				end
				BOOK_POP: begin
					if (i < DEPTH - 1) begin
						price_q[i] <= price_q[(i < DEPTH - 1) ? i + 1 : i];
						qty_q[i] <= qty_q[(i < DEPTH - 1) ? i + 1 : i];
						time_q[i] <= time_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
				BOOK_SETQ: begin
					if (i == 0) begin
						qty_q[i] <= set_qty;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (op)
				BOOK_INSERT: count_q <= count_q + CW'(1);
				BOOK_POP:    count_q <= count_q - CW'(1);
				default:     count_q <= count_q;
			endcase
		end
	end

	assign head_price = price_q[0];
	assign head_qty = qty_q[0];
	assign nonempty = count_q != '0;
	assign full = count_q >= CW'(DEPTH);

endmodule

FILE: src/lob_datapath.sv
module lob_datapath #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lob_pkg::SYM_W-1:0]       cfg_wdata,
	input  logic [lob_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [lob_pkg::S_TUSER_W-1:0]   s_tuser,
	input  lob_pkg::ctl_cmd_t               cmd,
	output lob_pkg::dp_stat_t               stat,
	output logic [lob_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tuser
);
	import lob_pkg::*;

	logic [SYM_W-1:0]   book_symbol_q;
	logic [SYM_W-1:0]   sym_q;
	logic [KIND_W-1:0]  kind_q;
	logic               side_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	logic [TIME_W-1:0]  time_q;

	logic [FILLS_W-1:0] fills_q;
	logic [VOL_W-1:0]   volume_q;

	logic [QTY_W-1:0]   pend_qty_q;
	logic [PRICE_W-1:0] pend_price_q;
	logic [FILLS_W-1:0] pend_fills_q;
	logic [VOL_W-1:0]   pend_volume_q;

	status_t            out_status_q;
	logic               out_fv_q;
	logic [QTY_W-1:0]   out_qty_q;
	logic [PRICE_W-1:0] out_price_q;
	logic [FILLS_W-1:0] out_fills_q;
	logic [VOL_W-1:0]   out_volume_q;

	book_op_t           bid_op, ask_op;
	logic [QTY_W-1:0]   bid_setq, ask_setq;
	logic [PRICE_W-1:0] bid_price, ask_price;
	logic [QTY_W-1:0]   bid_qty, ask_qty;
	logic               bid_nonempty, ask_nonempty, bid_full, ask_full;

	logic               q_eq, bid_larger;
	logic [QTY_W-1:0]   fill_qty;
	logic [FILLS_W-1:0] fills_next;
	logic [VOL_W-1:0]   volume_next;

	always_comb begin
		q_eq = bid_qty == ask_qty;
		bid_larger = bid_qty > ask_qty;
		fill_qty = bid_larger ? ask_qty : bid_qty;
		fills_next = fills_q + (q_eq ? FILLS_W'(2) : FILLS_W'(1));
		volume_next = volume_q + VOL_W'(fill_qty);
		bid_setq = bid_qty - ask_qty;
		ask_setq = ask_qty - bid_qty;

		bid_op = BOOK_HOLD;
		ask_op = BOOK_HOLD;
		if (cmd.insert) begin
			if (side_q == SIDE_BUY) begin
				bid_op = BOOK_INSERT;
			end else begin
				ask_op = BOOK_INSERT;
			end
		end else if (cmd.match) begin
			if (q_eq) begin
				bid_op = BOOK_POP;
				ask_op = BOOK_POP;
			end else if (bid_larger) begin
				bid_op = BOOK_SETQ;
				ask_op = BOOK_POP;
			end else begin
				bid_op = BOOK_POP;
				ask_op = BOOK_SETQ;
			end
		end

		if (sym_q != book_symbol_q) begin
			stat.check = ST_SYMBOL;
		end else if (kind_q != KIND_LIMIT) begin
			stat.check = ST_KIND;
		end else if ((side_q == SIDE_BUY) ? bid_full : ask_full) begin
			stat.check = ST_FULL;
		end else begin
			stat.check = ST_ACCEPTED;
		end
		stat.crossed = bid_nonempty && ask_nonempty && (bid_price >= ask_price);
	end

	lob_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b1)) u_bid (
		.clk(clk), .arst_n(arst_n), .op(bid_op),
		.new_price(price_q), .new_qty(qty_q), .new_time(time_q), .set_qty(bid_setq),
		.head_price(bid_price), .head_qty(bid_qty),
		.nonempty(bid_nonempty), .full(bid_full)
	);

	lob_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b0)) u_ask (
		.clk(clk), .arst_n(arst_n), .op(ask_op),
		.new_price(price_q), .new_qty(qty_q), .new_time(time_q), .set_qty(ask_setq),
		.head_price(ask_price), .head_qty(ask_qty),
		.nonempty(ask_nonempty), .full(ask_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			book_symbol_q <= '0;
			fills_q <= '0;
			volume_q <= '0;
		end else begin
			if (cfg_we) begin
				book_symbol_q <= cfg_wdata;
			end
			if (cmd.match) begin
				fills_q <= fills_next;
				volume_q <= volume_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sym_q <= s_tdata[15:0];
			side_q <= s_tdata[16];
			price_q <= s_tdata[48:17];
			qty_q <= s_tdata[80:49];
			time_q <= s_tdata[128:81];
			kind_q <= s_tuser;
		end
		// The fill is held back in the pend registers until it is known whether another follows.
		if (cmd.match) begin
			pend_qty_q <= fill_qty;
			pend_price_q <= ask_price;
			pend_fills_q <= fills_next;
			pend_volume_q <= volume_next;
		end
		case (cmd.out_sel)
			OUT_PLAIN: begin
				out_status_q <= cmd.out_status;
				out_fv_q <= 1'b0;
				out_qty_q <= '0;
				out_price_q <= '0;
				out_fills_q <= fills_q;
				out_volume_q <= volume_q;
			end
			OUT_PEND: begin
				out_status_q <= ST_ACCEPTED;
				out_fv_q <= 1'b1;
				out_qty_q <= pend_qty_q;
				out_price_q <= pend_price_q;
				out_fills_q <= pend_fills_q;
				out_volume_q <= pend_volume_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {6'd0, out_volume_q, out_fills_q, out_price_q, out_qty_q, out_status_q};
	assign m_tuser = out_fv_q;

endmodule

FILE: src/lob_ctrl.sv
module lob_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic              m_tlast,
	input  lob_pkg::dp_stat_t stat,
	output lob_pkg::ctl_cmd_t cmd
);
	import lob_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		CHECK,
		EVAL,
		SEND
	} state_t;

	state_t         state_q;
	logic [K_W-1:0] k_q;
	logic           pend_q;
	logic           cross_ok;

	assign cross_ok = stat.crossed && (k_q < K_W'(RESULT_LIMIT));
	assign s_tready = state_q == IDLE;

	always_comb begin
		cmd = '{take: 1'b0, insert: 1'b0, match: 1'b0,
			out_sel: OUT_HOLD, out_status: ST_ACCEPTED};
		case (state_q)
			IDLE: cmd.take = s_tvalid;
			CHECK: begin
				if (stat.check != ST_ACCEPTED) begin
					cmd.out_sel = OUT_PLAIN;
					cmd.out_status = stat.check;
				end else begin
					cmd.insert = 1'b1;
				end
			end
			EVAL: begin
				cmd.match = cross_ok;
				if (pend_q) begin
					cmd.out_sel = OUT_PEND;
				end else if (!cross_ok) begin
					cmd.out_sel = OUT_PLAIN;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			k_q <= '0;
			pend_q <= 1'b0;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_tvalid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					k_q <= '0;
					pend_q <= 1'b0;
					if (stat.check != ST_ACCEPTED) begin
						m_tvalid <= 1'b1;
						m_tlast <= 1'b1;
						state_q <= SEND;
					end else begin
						state_q <= EVAL;
					end
				end
				EVAL: begin
					if (cross_ok) begin
						k_q <= k_q + K_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q || !cross_ok) begin
						m_tvalid <= 1'b1;
						m_tlast <= !cross_ok;
						state_q <= SEND;
					end
				end
				SEND: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						state_q <= m_tlast ? IDLE : EVAL;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

FILE: src/lob_checker.sv
module lob_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [lob_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast
);
	import lob_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_one_order: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("new order taken while a result is pending");

	a_reject_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_ACCEPTED |-> m_tlast && !m_tuser)
		else $error("rejected order with a fill or without tlast");

	a_fill_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == ST_ACCEPTED)
		else $error("fill reported with a reject status");

endmodule

bind limit_order_book_matcher_unit lob_checker u_lob_checker (.*);

FILE: dv/tb_limit_order_book_matcher_unit.sv
module tb_limit_order_book_matcher_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import lob_pkg::*;

	localparam int DEPTH = 32;
	localparam logic [1:0] KIND_CANCEL = 2'd1;
	localparam logic [1:0] KIND_REPLACE = 2'd2;
	localparam logic [1:0] KIND_OTHER = 2'd3;
	localparam logic SIDE_SELL = 1'b1;

	typedef struct {
		logic [15:0] sym;
		logic [1:0]  kind;
		logic        side;
		logic [31:0] price;
		logic [31:0] qty;
		logic [47:0] stamp;
	} order_t;

	typedef struct packed {
		status_t     status;
		logic        fv;
		logic [31:0] qty;
		logic [31:0] price;
		logic [31:0] filled;
		logic [63:0] vol;
		logic        last;
	} fill_t;

	typedef struct {
		order_t  ord;
		logic    fixed;
		status_t status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	limit_order_book_matcher_unit #(.BOOK_DEPTH(DEPTH)) dut (.*);

	always #2 clk = ~clk;

	// Shadow copy of the two books and the running totals.
	logic [15:0] sym_cfg;
	logic [31:0] bid_px[DEPTH], bid_qt[DEPTH], ask_px[DEPTH], ask_qt[DEPTH];
	logic [47:0] bid_tm[DEPTH], ask_tm[DEPTH];
	int bid_n, ask_n;
	logic [31:0] fills;
	logic [63:0] volume;
	fill_t pending_fills[$];
	int mismatches = 0;
	bit no_idle = 0;
	int rdy_gap = 0;

	function automatic fill_t mk(status_t st, logic fv, logic [31:0] q, logic [31:0] p,
			logic last);
		fill_t f;
		f.status = st; f.fv = fv; f.qty = q; f.price = p;
		f.filled = fills; f.vol = volume; f.last = last;
		return f;
	endfunction

	function automatic void pop_bid();
		for (int i = 1; i < bid_n; i++) begin
			bid_px[i-1] = bid_px[i]; bid_qt[i-1] = bid_qt[i]; bid_tm[i-1] = bid_tm[i];
		end
		bid_n--;
	endfunction

	function automatic void pop_ask();
		for (int i = 1; i < ask_n; i++) begin
			ask_px[i-1] = ask_px[i]; ask_qt[i-1] = ask_qt[i]; ask_tm[i-1] = ask_tm[i];
		end
		ask_n--;
	endfunction

	function automatic void match_order(order_t o);
		int pos;
		int k;
		logic [31:0] fq;
		if (o.sym != sym_cfg) begin
			pending_fills.push_back(mk(ST_SYMBOL, 1'b0, 32'd0, 32'd0, 1'b1));
			return;
		end
		if (o.kind != KIND_LIMIT) begin
			pending_fills.push_back(mk(ST_KIND, 1'b0, 32'd0, 32'd0, 1'b1));
			return;
		end
		if ((o.side == SIDE_BUY ? bid_n : ask_n) >= DEPTH) begin
			pending_fills.push_back(mk(ST_FULL, 1'b0, 32'd0, 32'd0, 1'b1));
			return;
		end
		if (o.side == SIDE_BUY) begin
			pos = bid_n;
			for (int i = 0; i < bid_n; i++)
				if (o.price > bid_px[i] || (o.price == bid_px[i] && o.stamp < bid_tm[i])) begin
					pos = i;
					break;
				end
			for (int i = bid_n; i > pos; i--) begin
				bid_px[i] = bid_px[i-1]; bid_qt[i] = bid_qt[i-1]; bid_tm[i] = bid_tm[i-1];
			end
			bid_px[pos] = o.price; bid_qt[pos] = o.qty; bid_tm[pos] = o.stamp;
			bid_n++;
		end else begin
			pos = ask_n;
			for (int i = 0; i < ask_n; i++)
				if (o.price < ask_px[i] || (o.price == ask_px[i] && o.stamp < ask_tm[i])) begin
					pos = i;
					break;
				end
			for (int i = ask_n; i > pos; i--) begin
				ask_px[i] = ask_px[i-1]; ask_qt[i] = ask_qt[i-1]; ask_tm[i] = ask_tm[i-1];
			end
			ask_px[pos] = o.price; ask_qt[pos] = o.qty; ask_tm[pos] = o.stamp;
			ask_n++;
		end
		k = 0;
		while (k < RESULT_LIMIT && bid_n > 0 && ask_n > 0 && bid_px[0] >= ask_px[0]) begin
			logic [31:0] fp;
			fp = ask_px[0];
			if (bid_qt[0] == ask_qt[0]) begin
				fq = bid_qt[0];
				fills += 32'd2;
				pop_bid();
				pop_ask();
			end else if (bid_qt[0] > ask_qt[0]) begin
				fq = ask_qt[0];
				fills += 32'd1;
				bid_qt[0] -= fq;
				pop_ask();
			end else begin
				fq = bid_qt[0];
				fills += 32'd1;
				ask_qt[0] -= fq;
				pop_bid();
			end
			volume += 64'(fq);
			pending_fills.push_back(mk(ST_ACCEPTED, 1'b1, fq, fp, 1'b0));
			k++;
		end
		if (k == 0)
			pending_fills.push_back(mk(ST_ACCEPTED, 1'b0, 32'd0, 32'd0, 1'b1));
		else
			pending_fills[$].last = 1'b1;
	endfunction

	task automatic send(order_t o, logic fixed = 1'b0, status_t st = ST_ACCEPTED);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, o.stamp, o.qty, o.price, o.side, o.sym};
		s_tuser <= o.kind;
		do @(posedge clk); while (!s_tready);
		if (fixed)
			pending_fills.push_back(mk(st, 1'b0, 32'd0, 32'd0, 1'b1));
		else
			match_order(o);
		@(negedge clk);
		gap = (!no_idle && $urandom_range(3) == 0) ? $urandom_range(1, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic quiesce_and_write(logic [15:0] v);
		s_tvalid <= 1'b0;
		while (pending_fills.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sym_cfg = v;
	endtask

	function automatic order_t rand_order(int band);
		order_t o;
		o.sym = ($urandom_range(9) == 0) ? 16'($urandom) : sym_cfg;
		o.kind = ($urandom_range(9) == 0) ? 2'($urandom) : KIND_LIMIT;
		o.side = 1'($urandom);
		o.price = (band == 0) ? $urandom : 32'd1000 + $urandom_range(40);
		o.qty = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(0, 60));
		o.stamp = 48'({$urandom, $urandom});
		if ($urandom_range(4) == 0) o.stamp = 48'($urandom_range(3));
		return o;
	endfunction

	always @(negedge clk) begin
		if (no_idle) begin
			m_tready <= 1'b1;
		end else if (rdy_gap > 0) begin
			rdy_gap <= rdy_gap - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(4) == 0) begin
			rdy_gap <= $urandom_range(0, 6);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			fill_t e;
			fill_t a;
			a.status = status_t'(m_tdata[1:0]);
			a.qty = m_tdata[33:2];
			a.price = m_tdata[65:34];
			a.filled = m_tdata[97:66];
			a.vol = m_tdata[161:98];
			a.fv = m_tuser;
			a.last = m_tlast;
			if (pending_fills.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result %p", $realtime, a);
			end else begin
				e = pending_fills.pop_front();
				if (e !== a) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected %p got %p", $realtime, e, a);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		row_t dir[$];
		order_t o;
		sym_cfg = '0;
		bid_n = 0; ask_n = 0; fills = '0; volume = '0;
		// Directed orders, with symbol 0 in force after reset.
		dir = '{
			'{'{16'hFFFF, KIND_LIMIT, SIDE_BUY, 32'd5, 32'd5, 48'd1}, 1, ST_SYMBOL},
			'{'{16'h0000, KIND_CANCEL, SIDE_BUY, 32'd5, 32'd5, 48'd1}, 1, ST_KIND},
			'{'{16'h0000, KIND_REPLACE, SIDE_SELL, 32'd5, 32'd5, 48'd1}, 1, ST_KIND},
			'{'{16'h0000, KIND_OTHER, SIDE_SELL, 32'd5, 32'd5, 48'd1}, 1, ST_KIND},
			'{'{16'h0001, KIND_OTHER, SIDE_SELL, 32'd5, 32'd5, 48'd1}, 1, ST_SYMBOL},
			'{'{16'h0000, KIND_LIMIT, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				48'hFFFF_FFFF_FFFF}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_SELL, 32'd0, 32'd1, 48'd0}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
				48'd0}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_SELL, 32'd100, 32'd0, 48'd7}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_BUY, 32'd100, 32'd0, 48'd7}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_BUY, 32'd50, 32'd10, 48'd9}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_BUY, 32'd50, 32'd20, 48'd9}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_BUY, 32'd50, 32'd30, 48'd3}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_SELL, 32'd40, 32'd45, 48'd2}, 0, ST_ACCEPTED},
			'{'{16'h0000, KIND_LIMIT, SIDE_SELL, 32'd50, 32'd15, 48'd2}, 0, ST_ACCEPTED}
		};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (dir[i]) send(dir[i].ord, dir[i].fixed, dir[i].status);

		quiesce_and_write(16'hFFFF);
		for (int i = 0; i < 60; i++) send(rand_order($urandom_range(9) == 0));
		quiesce_and_write(16'($urandom));
		for (int i = 0; i < 60; i++) send(rand_order($urandom_range(9) == 0));
		quiesce_and_write(16'h0000);
		for (int i = 0; i < 40; i++) send(rand_order(1));

		// Fill the ask side at the top price until it overflows, then sweep it.
		no_idle = 1;
		for (int i = 0; i < DEPTH + 2; i++) begin
			o = '{sym_cfg, KIND_LIMIT, SIDE_SELL, 32'hFFFF_FFFF,
				32'($urandom_range(1, 9)), 48'($urandom_range(5))};
			send(o);
		end
		o = '{sym_cfg, KIND_LIMIT, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0};
		send(o);
		for (int i = 0; i < 20; i++) send(rand_order(1));

		s_tvalid <= 1'b0;
		while (pending_fills.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

FILE: limit_order_book_matcher_unit.f
src/lob_pkg.sv
src/lob_book.sv
src/lob_datapath.sv
src/lob_ctrl.sv
src/limit_order_book_matcher_unit.sv
src/lob_checker.sv
dv/tb_limit_order_book_matcher_unit.sv
